/* rtl/sspp_pkg.sv */
// Shared types, constants and helpers for the stepper speed to step-period unit.
`timescale 1ns / 1ps

package sspp_pkg;

    // Default command width
    localparam int VELOCITY_WIDTH_DEF = 22;

    // Configuration register widths and reset values
    localparam int CLK_W      = 28;
    localparam int PSC_W      = 16;
    localparam int MS_W       = 3;
    localparam int CFG_DATA_W = 28;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLK_HZ    = 2'd0,
        CFG_PRESCALER = 2'd1,
        CFG_MICROSTEP = 2'd2
    } cfg_index_t;

    localparam logic [CLK_W-1:0] CLK_RESET = 28'd72000000;
    localparam logic [PSC_W-1:0] PSC_RESET = 16'd71;
    localparam logic [MS_W-1:0]  MS_RESET  = 3'd4;
    localparam logic [MS_W-1:0]  MS_MAX    = 3'd4;

    // Speed clamp, millideg/s
    localparam int SPEED_W = 21;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 21'd1502;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 21'd1081730;

    // Twice the step angle in millideg: numerator is tick * 2 * 1800
    localparam int STEP_W = 12;
    localparam logic [STEP_W-1:0] STEP_X2 = 12'd3600;

    // Datapath widths
    localparam int TICK_W = CLK_W;              // tick rate quotient
    localparam int NUM_W  = TICK_W + STEP_W;    // tick * 3600
    localparam int DEN_W  = SPEED_W + 4;        // speed << microstep (max 4)
    localparam int DVS_W  = DEN_W + 1;          // 2 * den
    localparam int QUO_W  = 17;                 // quotient bits kept
    localparam int REM_W  = DVS_W + QUO_W - 1;  // holds dvs << (QUO_W-1)
    localparam int CMP_W  = DVS_W + QUO_W;      // overflow compare width

    localparam logic [NUM_W-1:0] NUM_RESET =
        NUM_W'((64'(CLK_RESET) / (64'(PSC_RESET) + 64'd1)) * 64'(STEP_X2));

    // Output saturation limits
    localparam logic [15:0] RELOAD_MIN = 16'd90;
    localparam logic [15:0] RELOAD_MAX = 16'hFFFF;

    // Fields that ride along with the quotient
    typedef struct packed {
        logic       dir_update;
        logic       dir_level;
        logic [2:0] pins;
    } side_t;

    // Word handed from cell to cell
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
        logic             ovf;
        side_t            side;
    } cell_t;

    // Codes above sixteenth step act as full step
    function automatic logic [MS_W-1:0] ms_effective(input logic [MS_W-1:0] code);
        return (code > MS_MAX) ? '0 : code;
    endfunction

    // MS3..MS1 pin pattern
    function automatic logic [2:0] ms_pins(input logic [MS_W-1:0] code);
        logic [2:0] p;
        unique case (code)
            3'd1:    p = 3'b001;
            3'd2:    p = 3'b010;
            3'd3:    p = 3'b011;
            3'd4:    p = 3'b111;
            default: p = 3'b000;
        endcase
        return p;
    endfunction

endpackage

/* rtl/sspp_cmd_if.sv */
// Command channel: motor select and signed velocity.
`timescale 1ns / 1ps

interface sspp_cmd_if #(
    parameter int VELOCITY_WIDTH = sspp_pkg::VELOCITY_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic [7:0]                       motor_select;
    logic signed [VELOCITY_WIDTH-1:0] velocity_mdeg;

    modport source (output valid, motor_select, velocity_mdeg, input ready);
    modport sink   (input valid, motor_select, velocity_mdeg, output ready);
endinterface

/* rtl/sspp_res_if.sv */
// Result channel: direction, timer reload/compare and microstep pins.
`timescale 1ns / 1ps

interface sspp_res_if;
    logic        valid;
    logic        ready;
    logic        dir_update;
    logic        dir_level;
    logic [15:0] reload_value;
    logic [15:0] compare_value;
    logic [2:0]  microstep_pins;

    modport source (output valid, dir_update, dir_level, reload_value, compare_value,
                    microstep_pins, input ready);
    modport sink   (input valid, dir_update, dir_level, reload_value, compare_value,
                    microstep_pins, output ready);
endinterface

/* rtl/sspp_tick_div.sv */
// Serial divider for tick = clock / (prescaler + 1), then scaling by 3600.
`timescale 1ns / 1ps

module sspp_tick_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sspp_pkg::CLK_W-1:0]    clk_hz,
    input  logic [sspp_pkg::PSC_W-1:0]    psc,
    output logic                          busy,
    output logic [sspp_pkg::NUM_W-1:0]    num2
);
    localparam int CNT_W = $clog2(sspp_pkg::TICK_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sspp_pkg::TICK_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [sspp_pkg::TICK_W-1:0]     dvd_reg, dvd_next;
    logic [sspp_pkg::PSC_W-1:0]      rem_reg, rem_next;
    logic [sspp_pkg::NUM_W-1:0]      num2_reg, num2_next;

    logic [sspp_pkg::PSC_W:0]        dvs;
    logic [sspp_pkg::PSC_W:0]        trial;
    logic                            take;

    // One restoring step per cycle, MSB first
    assign dvs   = {1'b0, psc} + 17'd1;
    assign trial = {rem_reg, dvd_reg[sspp_pkg::TICK_W-1]};
    assign take  = (trial >= dvs);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        num2_next  = num2_reg;
        if (start)
        begin
            state_next = S_DIV;
            cnt_next   = '0;
            dvd_next   = clk_hz;
            rem_next   = '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                end
                S_DIV:
                begin
                    rem_next = take ? sspp_pkg::PSC_W'(trial - dvs)
                                    : trial[sspp_pkg::PSC_W-1:0];
                    dvd_next = {dvd_reg[sspp_pkg::TICK_W-2:0], take};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = S_MUL;
                    end
                end
                S_MUL:
                begin
                    num2_next  = sspp_pkg::NUM_W'(dvd_reg) *
                                 sspp_pkg::NUM_W'(sspp_pkg::STEP_X2);
                    state_next = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            num2_reg  <= sspp_pkg::NUM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dvd_reg   <= dvd_next;
            rem_reg   <= rem_next;
            num2_reg  <= num2_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign num2 = num2_reg;

endmodule

/* rtl/sspp_div_cell.sv */
// One quotient-bit cell of the pipelined period divider.
`timescale 1ns / 1ps

module sspp_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  sspp_pkg::cell_t up_data,
    output logic            dn_valid,
    input  logic            dn_ready,
    output sspp_pkg::cell_t dn_data
);
    logic                         vld_reg, vld_next;
    sspp_pkg::cell_t              data_reg, data_next;
    logic [sspp_pkg::REM_W-1:0]   sub;
    logic [sspp_pkg::REM_W:0]     diff;
    logic                         take;

    // Trial subtract of divisor weighted by this cell's bit
    assign sub  = sspp_pkg::REM_W'(up_data.dvs) << SHIFT;
    assign diff = {1'b0, up_data.rem} - {1'b0, sub};
    assign take = !diff[sspp_pkg::REM_W];

    always_comb
    begin
        data_next     = up_data;
        data_next.rem = take ? diff[sspp_pkg::REM_W-1:0] : up_data.rem;
        data_next.quo = {up_data.quo[sspp_pkg::QUO_W-2:0], take};
    end

    // Stage holds when full and downstream stalls
    assign up_ready = !vld_reg || dn_ready;
    assign vld_next = up_ready ? up_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/stepper_speed_to_pwm_period_unit.sv */
// Top level: velocity command to step direction, timer reload/compare and microstep pins.
// Registers from an accepted word to its result word: entry, prep, 17 divider cells,
// output register. Throughput: one word per cycle, set by the 17-cell divider row, while
// neither side stalls. A write of timer_clock_hz or prescaler holds cmd.ready low while
// the serial tick divider (one bit per cycle, 28 bits) and the scaling multiply run.
// Reset: registers take their defaults with the scaled tick preloaded; pipeline empty.
`timescale 1ns / 1ps

module stepper_speed_to_pwm_period_unit #(
    parameter int VELOCITY_WIDTH = sspp_pkg::VELOCITY_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sspp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sspp_pkg::CFG_DATA_W-1:0]   cfg_data,
    sspp_cmd_if.sink                          cmd,
    sspp_res_if.source                        res
);
    localparam int MAG_W = (VELOCITY_WIDTH > sspp_pkg::SPEED_W) ? VELOCITY_WIDTH
                                                                : sspp_pkg::SPEED_W;
    localparam int NQ = sspp_pkg::QUO_W;

    // ---------------- configuration registers ----------------
    logic [sspp_pkg::CLK_W-1:0] clk_hz_reg, clk_hz_next;
    logic [sspp_pkg::PSC_W-1:0] psc_reg, psc_next;
    logic [sspp_pkg::MS_W-1:0]  ms_reg, ms_next;
    logic                       start_reg, start_next;
    logic                       tick_busy;
    logic                       cfg_busy;
    logic [sspp_pkg::NUM_W-1:0] num2;

    always_comb
    begin
        clk_hz_next = clk_hz_reg;
        psc_next    = psc_reg;
        ms_next     = ms_reg;
        start_next  = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                sspp_pkg::CFG_CLK_HZ:
                begin
                    clk_hz_next = cfg_data[sspp_pkg::CLK_W-1:0];
                    start_next  = 1'b1;
                end
                sspp_pkg::CFG_PRESCALER:
                begin
                    psc_next   = cfg_data[sspp_pkg::PSC_W-1:0];
                    start_next = 1'b1;
                end
                sspp_pkg::CFG_MICROSTEP:
                begin
                    ms_next = cfg_data[sspp_pkg::MS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= sspp_pkg::CLK_RESET;
            psc_reg    <= sspp_pkg::PSC_RESET;
            ms_reg     <= sspp_pkg::MS_RESET;
            start_reg  <= 1'b0;
        end
        else
        begin
            clk_hz_reg <= clk_hz_next;
            psc_reg    <= psc_next;
            ms_reg     <= ms_next;
            start_reg  <= start_next;
        end
    end

    sspp_tick_div u_tick_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .clk_hz (clk_hz_reg),
        .psc    (psc_reg),
        .busy   (tick_busy),
        .num2   (num2)
    );

    assign cfg_busy = start_reg || tick_busy;

    // ---------------- entry stage: direction, magnitude clamp ----------------
    logic                             ent_vld_reg;
    logic                             ent_up_ready;
    logic [sspp_pkg::SPEED_W-1:0]     ent_speed_reg;
    logic [sspp_pkg::MS_W-1:0]        ent_code_reg;
    sspp_pkg::side_t                  ent_side_reg;
    logic                             prep_up_ready;

    logic [VELOCITY_WIDTH-1:0]        vel_u;
    logic                             neg;
    logic [VELOCITY_WIDTH-1:0]        mag_v;
    logic [MAG_W-1:0]                 mag_x;
    logic [sspp_pkg::SPEED_W-1:0]     speed;
    logic [sspp_pkg::MS_W-1:0]        code_eff;
    sspp_pkg::side_t                  side_in;
    logic                             cmd_take;

    assign vel_u = cmd.velocity_mdeg;
    assign neg   = vel_u[VELOCITY_WIDTH-1];
    assign mag_v = neg ? (~vel_u + 1'b1) : vel_u;
    assign mag_x = MAG_W'(mag_v);

    always_comb
    begin
        priority if (mag_x < MAG_W'(sspp_pkg::SPEED_MIN))
        begin
            speed = sspp_pkg::SPEED_MIN;
        end
        else if (mag_x > MAG_W'(sspp_pkg::SPEED_MAX))
        begin
            speed = sspp_pkg::SPEED_MAX;
        end
        else
        begin
            speed = sspp_pkg::SPEED_W'(mag_x);
        end
    end

    // Left motor: negative drives 1; right motor: negative drives 0
    always_comb
    begin
        side_in.pins = sspp_pkg::ms_pins(code_eff);
        priority if (cmd.motor_select == 8'd1)
        begin
            side_in.dir_update = 1'b1;
            side_in.dir_level  = neg;
        end
        else if (cmd.motor_select == 8'd0)
        begin
            side_in.dir_update = 1'b1;
            side_in.dir_level  = !neg;
        end
        else
        begin
            side_in.dir_update = 1'b0;
            side_in.dir_level  = 1'b0;
        end
    end

    assign code_eff     = sspp_pkg::ms_effective(ms_reg);
    assign ent_up_ready = !ent_vld_reg || prep_up_ready;
    assign cmd.ready    = ent_up_ready && !cfg_busy;
    assign cmd_take     = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= 1'b0;
        end
        else if (ent_up_ready)
        begin
            ent_vld_reg <= cmd_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            ent_speed_reg <= speed;
            ent_code_reg  <= code_eff;
            ent_side_reg  <= side_in;
        end
    end

    // ---------------- prep stage: numerator, divisor, overflow ----------------
    logic                             prep_vld_reg;
    sspp_pkg::cell_t                  prep_data_reg;
    sspp_pkg::cell_t                  prep_data_next;
    logic [sspp_pkg::DEN_W-1:0]       den;
    logic [sspp_pkg::NUM_W:0]         numer;
    logic [sspp_pkg::DVS_W-1:0]       dvs;

    sspp_pkg::cell_t                  chain_data [0:NQ];
    logic                             chain_vld  [0:NQ];
    logic                             chain_rdy  [0:NQ];

    assign den   = sspp_pkg::DEN_W'(ent_speed_reg) << ent_code_reg;
    assign numer = {1'b0, num2} + (sspp_pkg::NUM_W + 1)'(den);
    assign dvs   = {den, 1'b0};

    always_comb
    begin
        prep_data_next.rem  = sspp_pkg::REM_W'(numer);
        prep_data_next.dvs  = dvs;
        prep_data_next.quo  = '0;
        prep_data_next.ovf  = (sspp_pkg::CMP_W'(numer) >= {dvs, {NQ{1'b0}}});
        prep_data_next.side = ent_side_reg;
    end

    assign prep_up_ready = !prep_vld_reg || chain_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
        end
        else if (prep_up_ready)
        begin
            prep_vld_reg <= ent_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_vld_reg && prep_up_ready)
        begin
            prep_data_reg <= prep_data_next;
        end
    end

    assign chain_data[0] = prep_data_reg;
    assign chain_vld[0]  = prep_vld_reg;

    // ---------------- divider row: one quotient bit per cell, MSB first ----------------
    for (genvar g = 0; g < NQ; g++)
    begin : g_cell
        sspp_div_cell #(
            .SHIFT (NQ - 1 - g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_vld[g]),
            .up_ready (chain_rdy[g]),
            .up_data  (chain_data[g]),
            .dn_valid (chain_vld[g+1]),
            .dn_ready (chain_rdy[g+1]),
            .dn_data  (chain_data[g+1])
        );
    end

    // ---------------- output stage: saturate, half-duty compare ----------------
    logic                 out_vld_reg;
    logic                 out_take;
    logic [NQ-1:0]        q;
    logic [15:0]          reload;
    logic [15:0]          compare;
    logic                 upd_reg;
    logic                 lvl_reg;
    logic [15:0]          reload_reg;
    logic [15:0]          compare_reg;
    logic [2:0]           pins_reg;

    assign q = chain_data[NQ].quo;

    always_comb
    begin
        priority if (chain_data[NQ].ovf || (q > (NQ'(sspp_pkg::RELOAD_MAX) + 1'b1)))
        begin
            reload = sspp_pkg::RELOAD_MAX;
        end
        else if (q < (NQ'(sspp_pkg::RELOAD_MIN) + 1'b1))
        begin
            reload = sspp_pkg::RELOAD_MIN;
        end
        else
        begin
            reload = 16'(q - 1'b1);
        end
    end

    assign compare = 16'((17'(reload) + 17'd1) >> 1);

    assign chain_rdy[NQ] = !out_vld_reg || res.ready;
    assign out_take      = chain_vld[NQ] && chain_rdy[NQ];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (chain_rdy[NQ])
        begin
            out_vld_reg <= chain_vld[NQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            upd_reg     <= chain_data[NQ].side.dir_update;
            lvl_reg     <= chain_data[NQ].side.dir_level;
            reload_reg  <= reload;
            compare_reg <= compare;
            pins_reg    <= chain_data[NQ].side.pins;
        end
    end

    assign res.valid          = out_vld_reg;
    assign res.dir_update     = upd_reg;
    assign res.dir_level      = lvl_reg;
    assign res.reload_value   = reload_reg;
    assign res.compare_value  = compare_reg;
    assign res.microstep_pins = pins_reg;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the stepper speed to step-period unit.
`timescale 1ns / 1ps

module testbench;

    localparam int VW           = sspp_pkg::VELOCITY_WIDTH_DEF;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 124;
    localparam int SETTLE       = 25;     // settling margin after the last result
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;

    localparam longint unsigned SPEED_FLOOR  = 1502;
    localparam longint unsigned SPEED_CEIL   = 1081730;
    localparam longint unsigned STEP_MDEG    = 1800;
    localparam longint unsigned RELOAD_FLOOR = 90;
    localparam longint unsigned RELOAD_CEIL  = 65535;

    // One result word, field by field
    typedef struct packed {
        logic        dir_update;
        logic        dir_level;
        logic [15:0] reload_value;
        logic [15:0] compare_value;
        logic [2:0]  microstep_pins;
    } step_word_t;

    // Predicts step timing words and checks them in order
    class step_period_scoreboard;
        step_word_t  expected_q[$];
        logic [27:0] clk_hz;
        logic [15:0] psc;
        logic [2:0]  ms_code;
        int          commands;
        int          results;
        int          failures;
        int          reported;

        function new();
            clk_hz   = sspp_pkg::CLK_RESET;
            psc      = sspp_pkg::PSC_RESET;
            ms_code  = sspp_pkg::MS_RESET;
            commands = 0;
            results  = 0;
            failures = 0;
            reported = 0;
        endfunction

        function void set_config(logic [27:0] c, logic [15:0] p, logic [2:0] m);
            clk_hz  = c;
            psc     = p;
            ms_code = m;
        endfunction

        function step_word_t predict_period(logic [7:0] sel, logic signed [VW-1:0] vel);
            step_word_t      w;
            longint          signed_vel;
            longint unsigned mag;
            longint unsigned tick;
            longint unsigned num;
            longint unsigned den;
            longint unsigned q;
            longint unsigned reload;
            logic [2:0]      code;
            logic            neg;

            neg        = vel[VW-1];
            signed_vel = vel;
            mag        = (signed_vel < 0) ? -signed_vel : signed_vel;

            // direction pin: left motor is inverted relative to right
            w.dir_update = (sel == 8'd0) || (sel == 8'd1);
            if (sel == 8'd1)
                w.dir_level = neg;
            else if (sel == 8'd0)
                w.dir_level = !neg;
            else
                w.dir_level = 1'b0;

            if (mag < SPEED_FLOOR) mag = SPEED_FLOOR;
            if (mag > SPEED_CEIL)  mag = SPEED_CEIL;

            // codes past sixteenth step fall back to full step
            code = (ms_code > 3'd4) ? 3'd0 : ms_code;
            case (code)
                3'd1:    w.microstep_pins = 3'b001;
                3'd2:    w.microstep_pins = 3'b010;
                3'd3:    w.microstep_pins = 3'b011;
                3'd4:    w.microstep_pins = 3'b111;
                default: w.microstep_pins = 3'b000;
            endcase

            // round half up, then saturate
            tick = longint'(clk_hz) / (longint'(psc) + 1);
            num  = tick * STEP_MDEG;
            den  = mag << code;
            q    = (2 * num + den) / (2 * den);
            if (q < RELOAD_FLOOR + 1)
                reload = RELOAD_FLOOR;
            else if (q - 1 > RELOAD_CEIL)
                reload = RELOAD_CEIL;
            else
                reload = q - 1;

            w.reload_value  = reload[15:0];
            w.compare_value = 16'((reload + 1) / 2);
            return w;
        endfunction

        function void note_command(logic [7:0] sel, logic signed [VW-1:0] vel);
            expected_q.push_back(predict_period(sel, vel));
            commands++;
        endfunction

        function void check_result(step_word_t got);
            step_word_t want;

            results++;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (reported < 10)
                    $display("unexpected result word: reload=%0d compare=%0d",
                             got.reload_value, got.compare_value);
                reported++;
                return;
            end
            want = expected_q.pop_front();
            if (got.dir_update     !== want.dir_update   ||
                got.dir_level      !== want.dir_level    ||
                got.reload_value   !== want.reload_value ||
                got.compare_value  !== want.compare_value ||
                got.microstep_pins !== want.microstep_pins)
            begin
                failures++;
                if (reported < 10)
                begin
                    $display("mismatch on result %0d: expected upd=%0d lvl=%0d reload=%0d cmp=%0d pins=%03b",
                             results, want.dir_update, want.dir_level, want.reload_value,
                             want.compare_value, want.microstep_pins);
                    $display("    got upd=%0d lvl=%0d reload=%0d cmp=%0d pins=%03b",
                             got.dir_update, got.dir_level, got.reload_value,
                             got.compare_value, got.microstep_pins);
                end
                reported++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
            begin
                failures += expected_q.size();
                $display("%0d expected result words never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [sspp_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [sspp_pkg::CFG_DATA_W-1:0]    cfg_data;

    sspp_cmd_if #(.VELOCITY_WIDTH(VW)) cmd_bus ();
    sspp_res_if                        res_bus ();

    step_period_scoreboard periods = new();

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_trigger;
    int settings_used;

    // Register settings per phase; phase 0 keeps reset values, the last is random
    logic [27:0] phase_clk [NUM_PHASES] = '{28'd0, 28'd72000000, 28'd268435455, 28'd1,
                                            28'd0, 28'd16000000, 28'd268435455,
                                            28'd100000000, 28'd84000000, 28'd0};
    logic [15:0] phase_psc [NUM_PHASES] = '{16'd0, 16'd71, 16'd0, 16'd0, 16'd5, 16'd15,
                                            16'd65535, 16'd99, 16'd83, 16'd0};
    logic [2:0]  phase_ms  [NUM_PHASES] = '{3'd0, 3'd0, 3'd4, 3'd3, 3'd2, 3'd1, 3'd5,
                                            3'd6, 3'd7, 3'd0};

    // Speeds around every clamp edge and the ends of the field
    logic signed [VW-1:0] edge_speeds [14] = '{22'sd0, 22'sd1, -22'sd1, 22'sd1501,
                                               22'sd1502, 22'sd1503, -22'sd1502,
                                               22'sd1081729, 22'sd1081730, 22'sd1081731,
                                               -22'sd1081730, -22'sd1081731,
                                               22'sd2097151, -22'sd2097152};

    stepper_speed_to_pwm_period_unit #(.VELOCITY_WIDTH(VW)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .res       (res_bus)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Accepted command words go to the scoreboard; accepted result words are checked
    always @(posedge clk)
    begin
        if (rst_n && cmd_bus.valid && cmd_bus.ready)
            periods.note_command(cmd_bus.motor_select, cmd_bus.velocity_mdeg);
        if (rst_n && res_bus.valid && res_bus.ready)
            periods.check_result('{dir_update:     res_bus.dir_update,
                                   dir_level:      res_bus.dir_level,
                                   reload_value:   res_bus.reload_value,
                                   compare_value:  res_bus.compare_value,
                                   microstep_pins: res_bus.microstep_pins});
    end

    // Result side: random stalls, plus long hold-offs on request
    initial
    begin
        int hold_left;
        int hold_done;

        hold_left = 0;
        hold_done = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                res_bus.ready <= 1'b0;
            else if (hold_trigger != hold_done)
            begin
                hold_done = hold_trigger;
                hold_left = HOLD_CYCLES;
                res_bus.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: too long without any word moving
    initial
    begin
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one command word and wait for it to be taken
    task automatic send_command(logic [7:0] sel, logic signed [VW-1:0] vel);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.motor_select  <= sel;
        cmd_bus.velocity_mdeg <= vel;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
    endtask

    task automatic send_random_command();
        logic [7:0]           sel;
        logic signed [VW-1:0] vel;
        int                   pick;

        pick = $urandom_range(99);
        if (pick < 40)
            sel = 8'd0;
        else if (pick < 80)
            sel = 8'd1;
        else
            sel = 8'($urandom_range(255));

        pick = $urandom_range(99);
        if (pick < 10)
            vel = edge_speeds[$urandom_range(13)];
        else if (pick < 30)
            vel = VW'($urandom);
        else
        begin
            vel = VW'($urandom_range(1100000, 1));
            if ($urandom_range(1))
                vel = -vel;
        end
        send_command(sel, vel);
    endtask

    // Stop offering and wait until every expected word is back
    task automatic wait_for_results(int settle);
        cmd_bus.valid <= 1'b0;
        // let the clock advance so the last accepted word is already on the scoreboard
        @(posedge clk);
        while (periods.outstanding() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges
    task automatic apply_config(logic [27:0] c, logic [15:0] p, logic [2:0] m);
        cfg_we    <= 1'b1;
        cfg_index <= sspp_pkg::CFG_CLK_HZ;
        cfg_data  <= c;
        @(posedge clk);
        // upper data bits are don't-care for the narrow registers
        cfg_index <= sspp_pkg::CFG_PRESCALER;
        cfg_data  <= {12'($urandom), p};
        @(posedge clk);
        cfg_index <= sspp_pkg::CFG_MICROSTEP;
        cfg_data  <= {25'($urandom), m};
        @(posedge clk);
        cfg_we    <= 1'b0;
        periods.set_config(c, p, m);
        settings_used++;
    endtask

    // Main sequence
    initial
    begin
        logic [27:0] c;
        logic [15:0] p;
        logic [2:0]  m;

        tx_idle_pct   = 21;
        hold_trigger  = 0;
        settings_used = 1;
        rx_idle_pct           <= 66;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= sspp_pkg::CFG_CLK_HZ;
        cfg_data              <= '0;
        cmd_bus.valid         <= 1'b0;
        cmd_bus.motor_select  <= '0;
        cmd_bus.velocity_mdeg <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: clamp edges on both motors, then unknown selects
        for (int i = 0; i < 14; i++)
            send_command(8'(i % 2), edge_speeds[i]);
        send_command(8'd2, -22'sd50000);
        send_command(8'd255, 22'sd50000);
        send_command(8'd128, -22'sd2097152);
        send_command(8'd127, 22'sd0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_for_results(SETTLE);
                c = phase_clk[ph];
                p = phase_psc[ph];
                m = phase_ms[ph];
                if (ph == NUM_PHASES - 1)
                begin
                    c = 28'($urandom_range(268435455, 1));
                    p = 16'($urandom_range(300));
                    m = 3'($urandom_range(7));
                end
                apply_config(c, p, m);
            end

            // sender-light/receiver-heavy, then the reverse, then free running
            if (ph < 4)
            begin
                tx_idle_pct = 21;
                rx_idle_pct <= 66;
            end
            else if (ph < 7)
            begin
                tx_idle_pct = 66;
                rx_idle_pct <= 21;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long result hold-off while commands keep coming
                if ((ph == 1 || ph == 7) && i == 40)
                    hold_trigger <= hold_trigger + 1;
                // sender pauses until the pipe is empty
                if (ph == 5 && i == 60)
                    wait_for_results(0);
                send_random_command();
            end
        end

        wait_for_results(SETTLE);
        periods.close_out();
        $display("Covered %0d commands over %0d register settings, with stalls on both sides,",
                 periods.commands, settings_used);
        $display("long result hold-offs and drained pauses; %0d results checked, %0d failures.",
                 periods.results, periods.failures);
        if (periods.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/sspp_pkg.sv
rtl/sspp_cmd_if.sv
rtl/sspp_res_if.sv
rtl/sspp_tick_div.sv
rtl/sspp_div_cell.sv
rtl/stepper_speed_to_pwm_period_unit.sv
tb/testbench.sv
